/* hw/rtl/b32enc_pkg.sv */
// shared types, constants and the symbol lookup for the base32 encoder
// no dependencies; used by front end, job queue, back end and top level

package b32enc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_DIGIT = 8'h32;
    localparam logic [4:0] SYM_DIGITS = 5'd26;
    localparam logic [3:0] GROUP_LEN  = 4'd8;

    // one byte worth of work: data symbols in order, then padding
    typedef struct packed {
        logic [2:0][4:0] sym;
        logic [1:0]      nchar;
        logic [2:0]      npad;
        logic            last;
    } job_t;

    function automatic logic [7:0] sym_to_char(input logic [4:0] sym);
        logic [7:0] result;
        if (sym < SYM_DIGITS)
        begin
            result = CHAR_UPPER + {3'b000, sym};
        end
        else
        begin
            result = CHAR_DIGIT + {3'b000, sym - SYM_DIGITS};
        end
        return result;
    endfunction

endpackage

/* hw/rtl/b32enc_front.sv */
// front end: takes input transfers, slices pending bits into symbols, plans padding
// depends on b32enc_pkg for job_t and group constants

module b32enc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic               queue_full,
    output logic               in_stall,
    output logic               push,
    output b32enc_pkg::job_t   job
);

    logic [3:0]  pend_reg, pend_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  gp_reg, gp_next;

    logic [11:0] bits;
    logic [3:0]  total;
    logic        two;
    logic [2:0]  rem;
    logic [4:0]  sym0, sym1, sym_left;
    logic        have_left;
    logic [1:0]  nchar;
    logic [2:0]  gp_after;
    logic [2:0]  pad;
    logic [3:0]  room;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        bits      = {pend_reg, data_byte};
        total     = {1'b0, cnt_reg} + 4'd8;
        two       = (total >= 4'd10);
        rem       = two ? 3'(total - 4'd10) : 3'(total - 4'd5);
        sym0      = 5'(bits >> (total - 4'd5));
        sym1      = 5'(bits >> (total - 4'd10));
        sym_left  = 5'(bits << (3'd5 - rem));
        have_left = last_byte && (rem != 3'd0);
        nchar     = 2'd1 + {1'b0, two} + {1'b0, have_left};
        gp_after  = gp_reg + {1'b0, nchar};
        pad       = last_byte ? (3'd0 - gp_after) : 3'd0;
        room      = b32enc_pkg::GROUP_LEN - {2'b00, nchar};

        job.sym[0] = sym0;
        job.sym[1] = two ? sym1 : sym_left;
        job.sym[2] = sym_left;
        job.nchar  = nchar;
        // never more than one group of characters per byte
        job.npad   = ({1'b0, pad} > room) ? room[2:0] : pad;
        job.last   = last_byte;

        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        gp_next   = gp_reg;
        if (push)
        begin
            if (last_byte)
            begin
                pend_next = 4'd0;
                cnt_next  = 3'd0;
                gp_next   = 3'd0;
            end
            else
            begin
                pend_next = bits[3:0];
                cnt_next  = rem;
                gp_next   = gp_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 4'd0;
            cnt_reg  <= 3'd0;
            gp_reg   <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            gp_reg   <= gp_next;
        end
    end

endmodule

/* hw/rtl/b32enc_queue.sv */
// short job queue between front end and back end
// depends on b32enc_pkg for job_t and queue sizing

module b32enc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b32enc_pkg::job_t   push_job,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output b32enc_pkg::job_t   head_job
);

    localparam int DEPTH = b32enc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = b32enc_pkg::QUEUE_PTR_W;
    localparam int CNT_W = b32enc_pkg::QUEUE_CNT_W;

    b32enc_pkg::job_t slot_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/b32enc_back.sv */
// back end: head job to output register, one character per cycle unless stalled
// depends on b32enc_pkg for job_t, the symbol lookup and the pad character

module b32enc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  b32enc_pkg::job_t   head_job,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [7:0]         code_char,
    output logic               last_char
);

    logic [3:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] code_char_reg, code_char_next;
    logic       last_char_reg, last_char_next;

    logic [3:0] job_len;
    logic       fire;
    logic       final_char;

    assign out_valid = out_valid_reg;
    assign code_char = code_char_reg;
    assign last_char = last_char_reg;

    always_comb
    begin
        job_len    = {2'b00, head_job.nchar} + {1'b0, head_job.npad};
        fire       = head_valid && (!out_valid_reg || !out_stall);
        final_char = (idx_reg == job_len - 4'd1);
        pop        = fire && final_char;

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        code_char_next = code_char_reg;
        last_char_next = last_char_reg;

        if (fire)
        begin
            out_valid_next = 1'b1;
            if (idx_reg < {2'b00, head_job.nchar})
            begin
                code_char_next = b32enc_pkg::sym_to_char(head_job.sym[idx_reg[1:0]]);
            end
            else
            begin
                code_char_next = b32enc_pkg::PAD_CHAR;
            end
            last_char_next = head_job.last && final_char;
            idx_next       = final_char ? 4'd0 : idx_reg + 4'd1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_char_reg <= code_char_next;
        last_char_reg <= last_char_next;
    end

    // position within the head job stays inside it
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < job_len))
        else $error("character index past end of job");

    // no job in hand means the walk sits at its start
    assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (idx_reg == 4'd0))
        else $error("character index moved without a job");

    // a job leaves the queue only with its final character going out
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && (last_char_reg == $past(head_job.last))))
        else $error("job retired without its final character");

endmodule

/* hw/rtl/base32_stream_encoder.sv */
// base32 stream encoder: one input byte in, base32 characters out, '=' padded groups
// a byte's job is registered in the job queue, then each of its characters in the back end's output register
// throughput: one character per cycle while out_stall is low; a byte gives one or two characters, a last byte up to 8
// the output rate is set by the single-character output register in the back end
// reset: asynchronous, active low; clears bit state, queue pointers and output valid
// depends on b32enc_pkg, b32enc_front, b32enc_queue, b32enc_back

module base32_stream_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] code_char,
    output logic       last_char
);

    logic             push;
    logic             pop;
    logic             queue_full;
    logic             head_valid;
    b32enc_pkg::job_t push_job;
    b32enc_pkg::job_t head_job;

    b32enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .job        (push_job)
    );

    b32enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b32enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .code_char  (code_char),
        .last_char  (last_char)
    );

endmodule

/* bench/tb_base32_stream_encoder.sv */
`timescale 1ns / 1ps
// testbench for base32_stream_encoder: directed rows, then random messages under idle and stall
// expected chars come from typed rows or a bit accumulator model; needs b32enc_pkg and the rtl

module tb_base32_stream_encoder;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    // typed_count of zero means the characters come from the model
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [3:0]  typed_count;
        logic [63:0] typed_text;
    } byte_row_t;

    localparam int NUM_ROWS     = 21;
    localparam int RANDOM_ITEMS = 128;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [255:0] ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  code_char;
    logic        last_char;

    // typed characters travel with the byte they belong to
    logic [3:0]  typed_count;
    logic [63:0] typed_text;

    logic [11:0] acc_bits;
    logic [3:0]  pending_bits;
    logic [2:0]  group_pos;

    enc_char_t   pending_chars [$];
    byte_row_t   byte_rows [NUM_ROWS];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          errors;
    int          cycle_count;

    base32_stream_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_char (code_char),
        .last_char (last_char)
    );

    always #5 clk = ~clk;

    // shift a byte into the accumulator and queue the characters it produces
    function automatic void encode_byte(input logic [7:0] b, input logic is_last,
                                        input logic [3:0] nexp, input logic [63:0] text);
        enc_char_t   chars [8];
        logic [11:0] shifted;
        logic [4:0]  sym;
        int          n;
        int          i;
        n = 0;
        acc_bits = {acc_bits[3:0], b};
        pending_bits = pending_bits + 4'd8;
        while (pending_bits >= 4'd5 && n < 8)
        begin
            shifted = acc_bits >> (pending_bits - 4'd5);
            sym = shifted[4:0];
            chars[n] = '{ALPHABET[8 * (31 - sym) +: 8], 1'b0};
            n++;
            group_pos = group_pos + 3'd1;
            pending_bits = pending_bits - 4'd5;
        end
        if (is_last)
        begin
            // leftover bits are zero-filled on the right
            if (pending_bits != 4'd0 && n < 8)
            begin
                shifted = acc_bits << (4'd5 - pending_bits);
                sym = shifted[4:0];
                chars[n] = '{ALPHABET[8 * (31 - sym) +: 8], 1'b0};
                n++;
                group_pos = group_pos + 3'd1;
            end
            while (group_pos != 3'd0 && n < 8)
            begin
                chars[n] = '{b32enc_pkg::PAD_CHAR, 1'b0};
                n++;
                group_pos = group_pos + 3'd1;
            end
            if (n > 0)
            begin
                chars[n - 1].last = 1'b1;
            end
            acc_bits = '0;
            pending_bits = '0;
            group_pos = '0;
        end
        if (nexp != 4'd0)
        begin
            n = nexp;
            for (i = 0; i < n; i++)
            begin
                chars[i] = '{text[8 * (7 - i) +: 8], is_last && (i == n - 1)};
            end
        end
        for (i = 0; i < n; i++)
        begin
            pending_chars.push_back(chars[i]);
        end
    endfunction

    // transfers on both channels are seen here, prediction before checking
    always @(posedge clk)
    begin : check_chars
        enc_char_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                encode_byte(data_byte, last_byte, typed_count, typed_text);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, got %h last %b",
                             $time, code_char, last_char);
                    errors++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (code_char !== want.ch)
                    begin
                        $display("%0t: code_char mismatch: expected %h, got %h",
                                 $time, want.ch, code_char);
                        errors++;
                    end
                    if (last_char !== want.last)
                    begin
                        $display("%0t: last_char mismatch: expected %b, got %b",
                                 $time, want.last, last_char);
                        errors++;
                    end
                end
            end
        end
        out_stall <= rst_n ? ($urandom_range(99) < recv_stall_pct) : 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** base32_stream_encoder: FAILED **");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last,
                             input logic [3:0] nexp, input logic [63:0] text);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        last_byte   <= is_last;
        typed_count <= nexp;
        typed_text  <= text;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_message(input int len);
        logic [7:0] b;
        for (int k = 0; k < len; k++)
        begin
            case ($urandom_range(9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_byte(b, k == len - 1, 4'd0, 64'd0);
        end
    endtask

    // hold the sender back until every queued character has been seen
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending_chars.size() != 0);
    endtask

    initial
    begin
        int phase_items;
        int len;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'd0;
        last_byte      = 1'b0;
        out_stall      = 1'b0;
        typed_count    = 4'd0;
        typed_text     = 64'd0;
        acc_bits       = '0;
        pending_bits   = '0;
        group_pos      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        errors         = 0;
        cycle_count    = 0;

        // one-byte messages, then 2..5 byte messages covering every amount of padding
        byte_rows = '{
            '{8'hFF, 1'b1, 4'd8, "74======"},
            '{8'h00, 1'b1, 4'd8, "AA======"},
            '{8'h80, 1'b0, 4'd0, 64'd0},
            '{8'h01, 1'b1, 4'd0, 64'd0},
            '{8'h55, 1'b0, 4'd0, 64'd0},
            '{8'hAA, 1'b0, 4'd0, 64'd0},
            '{8'h0F, 1'b1, 4'd0, 64'd0},
            '{8'hF0, 1'b0, 4'd0, 64'd0},
            '{8'h00, 1'b0, 4'd0, 64'd0},
            '{8'hFF, 1'b0, 4'd0, 64'd0},
            '{8'h3C, 1'b1, 4'd0, 64'd0},
            '{8'h00, 1'b0, 4'd0, 64'd0},
            '{8'h00, 1'b0, 4'd0, 64'd0},
            '{8'h00, 1'b0, 4'd0, 64'd0},
            '{8'h00, 1'b0, 4'd0, 64'd0},
            '{8'h00, 1'b1, 4'd0, 64'd0},
            '{8'hFF, 1'b0, 4'd0, 64'd0},
            '{8'hFF, 1'b0, 4'd0, 64'd0},
            '{8'hFF, 1'b0, 4'd0, 64'd0},
            '{8'hFF, 1'b0, 4'd0, 64'd0},
            '{8'hFF, 1'b1, 4'd0, 64'd0}
        };

        repeat (9)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            send_byte(byte_rows[r].data, byte_rows[r].last,
                      byte_rows[r].typed_count, byte_rows[r].typed_text);
        end
        in_valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
            endcase
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 4)
            begin
                // mostly short messages, now and then a longer one spanning several groups
                len = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                send_message(len);
                phase_items += len;
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (pending_chars.size() != 0)
        begin
            $display("%0t: characters missing: expected %0d more, got none",
                     $time, pending_chars.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("** base32_stream_encoder: PASSED **");
        end
        else
        begin
            $display("** base32_stream_encoder: FAILED **");
        end
        $finish;
    end

endmodule
